// ===== rtl/core/tzlc_pkg.sv =====
// Shared widths, constants, row table and types for the tunnel zone luminance calculator.
package tzlc_pkg;

  localparam int FLOW_W     = 16;
  localparam int LUM_IN_W   = 16;
  localparam int SPEED_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int K_W   = 13;
  localparam int EZ1_W = 19;
  localparam int EZ2_W = 18;
  localparam int TZ1_W = 17;
  localparam int TZ2_W = 15;
  localparam int TZ3_W = 14;
  localparam int BZ_W  = 10;
  localparam int XZ1_W = 12;
  localparam int XZ2_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_DESIGN_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_WAY      = 1'd1;

  localparam logic [SPEED_W-1:0] SPEED_UNSET = 8'd0;
  localparam logic [SPEED_W-1:0] SPEED_120   = 8'd120;
  localparam logic [SPEED_W-1:0] SPEED_100   = 8'd100;
  localparam logic [SPEED_W-1:0] SPEED_80    = 8'd80;
  localparam logic [SPEED_W-1:0] SPEED_60    = 8'd60;

  localparam int ROW_W = 3;
  localparam logic [ROW_W-1:0] ROW_120 = 3'd0;
  localparam logic [ROW_W-1:0] ROW_100 = 3'd1;
  localparam logic [ROW_W-1:0] ROW_80  = 3'd2;
  localparam logic [ROW_W-1:0] ROW_60  = 3'd3;
  localparam logic [ROW_W-1:0] ROW_LOW = 3'd4;

  // clamped flow offset from the low flow point, 0..span
  localparam int T_W = 10;
  localparam logic [T_W-1:0] SPAN_ONE = 10'd850;
  localparam logic [T_W-1:0] SPAN_TWO = 10'd470;
  localparam logic [T_W-1:0] LOW_ONE  = 10'd350;
  localparam logic [T_W-1:0] LOW_TWO  = 10'd180;

  localparam int KS_W = 11;
  localparam int BS_W = 14;

  // rounding numerators: 2*span_k*t + D and 2*span_b*t + 10D
  localparam int MK_W = 22;
  localparam int MB_W = 24;
  localparam logic [MB_W-1:0] SPAN10_ONE = 24'd8500;
  localparam logic [MB_W-1:0] SPAN10_TWO = 24'd4700;

  // exact reciprocal division: floor(x/d) = (x * ceil(2^S/d)) >> S
  localparam int QK_W = 11;
  localparam int QB_W = 10;
  localparam int SK   = MK_W + 11;
  localparam int RK_W = 24;
  localparam logic [RK_W-1:0] RK_ONE = RK_W'(((64'd1 << SK) + 64'd1699) / 64'd1700);
  localparam logic [RK_W-1:0] RK_TWO = RK_W'(((64'd1 << SK) + 64'd939) / 64'd940);
  localparam int SB   = MB_W + 15;
  localparam int RB_W = 26;
  localparam logic [RB_W-1:0] RB_ONE = RB_W'(((64'd1 << SB) + 64'd16999) / 64'd17000);
  localparam logic [RB_W-1:0] RB_TWO = RB_W'(((64'd1 << SB) + 64'd9399) / 64'd9400);

  // base * 4 / 5
  localparam int S5    = 15;
  localparam int R5X_W = 15;
  localparam logic [R5X_W-1:0] R5_X4 = R5X_W'(4 * (((64'd1 << S5) + 64'd4) / 64'd5));

  // entrance level * {15,5,2} / 100
  localparam int S100  = 30;
  localparam longint unsigned R100 = ((64'd1 << S100) + 64'd99) / 64'd100;
  localparam int R100X_W = 28;
  localparam logic [R100X_W-1:0] R100_X15 = R100X_W'(15 * R100);
  localparam logic [R100X_W-1:0] R100_X5  = R100X_W'(5 * R100);
  localparam logic [R100X_W-1:0] R100_X2  = R100X_W'(2 * R100);

  localparam int NSTG = 7;

  typedef struct packed {
    logic [K_W-1:0]  k_lo;
    logic [KS_W-1:0] k_span;
    logic [BZ_W-1:0] b_lo;
    logic [BS_W-1:0] b_span;
  } row_t;

  typedef struct packed {
    logic [SPEED_W-1:0] design_speed;
    logic               two_way;
  } cfg_t;

  typedef struct packed {
    logic [NSTG-1:0] adv;
  } pipe_ctrl_t;

  typedef struct packed {
    logic             status;
    logic [K_W-1:0]   reduction_factor;
    logic [EZ1_W-1:0] entrance_zone1;
    logic [EZ2_W-1:0] entrance_zone2;
    logic [TZ1_W-1:0] transition_zone1;
    logic [TZ2_W-1:0] transition_zone2;
    logic [TZ3_W-1:0] transition_zone3;
    logic [BZ_W-1:0]  base_zone1;
    logic [BZ_W-1:0]  base_zone2;
    logic [XZ1_W-1:0] exit_zone1;
    logic [XZ2_W-1:0] exit_zone2;
  } result_t;

  // row minimum and span; base minimum already divided by ten
  function automatic row_t row_lookup(input logic [ROW_W-1:0] row);
    row_t r;
    case (row)
      ROW_120: r = '{k_lo: 13'd5000, k_span: 11'd2000, b_lo: 10'd450, b_span: 14'd5500};
      ROW_100: r = '{k_lo: 13'd3500, k_span: 11'd1000, b_lo: 10'd300, b_span: 14'd3500};
      ROW_80:  r = '{k_lo: 13'd2500, k_span: 11'd1000, b_lo: 10'd150, b_span: 14'd2000};
      ROW_60:  r = '{k_lo: 13'd1500, k_span: 11'd700,  b_lo: 10'd100, b_span: 14'd1500};
      default: r = '{k_lo: 13'd1000, k_span: 11'd200,  b_lo: 10'd100, b_span: 14'd9000};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/tzlc_if.sv =====
// Request and result channel interfaces of the tunnel zone luminance calculator.
interface tzlc_in_if
  import tzlc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [FLOW_W-1:0]   traffic_flow;
  logic [LUM_IN_W-1:0] exterior_luminance;

  modport source (output valid, traffic_flow, exterior_luminance, input ready);
  modport sink   (input valid, traffic_flow, exterior_luminance, output ready);
endinterface

interface tzlc_out_if
  import tzlc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             status;
  logic [K_W-1:0]   reduction_factor;
  logic [EZ1_W-1:0] entrance_zone1;
  logic [EZ2_W-1:0] entrance_zone2;
  logic [TZ1_W-1:0] transition_zone1;
  logic [TZ2_W-1:0] transition_zone2;
  logic [TZ3_W-1:0] transition_zone3;
  logic [BZ_W-1:0]  base_zone1;
  logic [BZ_W-1:0]  base_zone2;
  logic [XZ1_W-1:0] exit_zone1;
  logic [XZ2_W-1:0] exit_zone2;

  modport source (output valid, status, reduction_factor, entrance_zone1, entrance_zone2,
                  transition_zone1, transition_zone2, transition_zone3, base_zone1,
                  base_zone2, exit_zone1, exit_zone2, input ready);
  modport sink   (input valid, status, reduction_factor, entrance_zone1, entrance_zone2,
                  transition_zone1, transition_zone2, transition_zone3, base_zone1,
                  base_zone2, exit_zone1, exit_zone2, output ready);
endinterface

// ===== rtl/core/tzlc_datapath.sv =====
// Seven-stage datapath: row interpolation, rounding and zone ratios.
module tzlc_datapath
  import tzlc_pkg::*;
#(
  parameter int LUM_W = 16
) (
  input  logic                clk,
  input  pipe_ctrl_t          ctrl,
  input  cfg_t                cfg,
  input  logic [FLOW_W-1:0]   flow_in,
  input  logic [LUM_IN_W-1:0] lum_in,
  output result_t             res
);

  localparam int PROD_W = K_W + LUM_W;
  localparam int SE     = PROD_W + 10;
  localparam int RE_W   = SE - 9;
  localparam int E_PW   = SE + EZ1_W;
  localparam logic [RE_W-1:0] RE = RE_W'(((64'd1 << SE) + 64'd999) / 64'd1000);
  localparam int K_PW   = MK_W + RK_W;
  localparam int B_PW   = MB_W + RB_W;
  localparam int B5_PW  = S5 + BZ_W;
  localparam int T_PW   = S100 + TZ1_W;

  // stage 0: request capture and row decode
  logic [FLOW_W-1:0] s0_flow_r;
  logic [LUM_W-1:0]  s0_lum_r;
  logic [ROW_W-1:0]  s0_row_r;
  logic              s0_two_r;
  logic              s0_bad_r;
  logic [ROW_W-1:0]  row_sel;

  always_comb begin
    case (cfg.design_speed)
      SPEED_120: row_sel = ROW_120;
      SPEED_100: row_sel = ROW_100;
      SPEED_80:  row_sel = ROW_80;
      SPEED_60:  row_sel = ROW_60;
      default:   row_sel = ROW_LOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[0]) begin
      s0_flow_r <= flow_in;
      s0_lum_r  <= lum_in[LUM_W-1:0];
      s0_row_r  <= row_sel;
      s0_two_r  <= cfg.two_way;
      s0_bad_r  <= (cfg.design_speed == SPEED_UNSET);
    end
  end

  // stage 1: clamp flow, build rounding numerators
  row_t              rw;
  logic [T_W-1:0]    low_pt;
  logic [T_W-1:0]    span;
  logic [FLOW_W-1:0] diff;
  logic [T_W-1:0]    t;
  logic [MK_W-1:0]   mk_nxt;
  logic [MB_W-1:0]   mb_nxt;
  logic [MK_W-1:0]   s1_mk_r;
  logic [MB_W-1:0]   s1_mb_r;
  logic [K_W-1:0]    s1_klo_r;
  logic [BZ_W-1:0]   s1_blo_r;
  logic              s1_two_r;
  logic              s1_bad_r;
  logic [LUM_W-1:0]  s1_lum_r;

  always_comb begin
    rw     = row_lookup(s0_row_r);
    low_pt = s0_two_r ? LOW_TWO : LOW_ONE;
    span   = s0_two_r ? SPAN_TWO : SPAN_ONE;
    diff   = s0_flow_r - FLOW_W'(low_pt);
    if (s0_flow_r < FLOW_W'(low_pt)) begin
      t = '0;
    end else if (diff >= FLOW_W'(span)) begin
      t = span;
    end else begin
      t = diff[T_W-1:0];
    end
    mk_nxt = ((MK_W'(rw.k_span) * MK_W'(t)) << 1) + MK_W'(span);
    mb_nxt = ((MB_W'(rw.b_span) * MB_W'(t)) << 1) + (s0_two_r ? SPAN10_TWO : SPAN10_ONE);
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv[1]) begin
      s1_mk_r  <= mk_nxt;
      s1_mb_r  <= mb_nxt;
      s1_klo_r <= rw.k_lo;
      s1_blo_r <= rw.b_lo;
      s1_two_r <= s0_two_r;
      s1_bad_r <= s0_bad_r;
      s1_lum_r <= s0_lum_r;
    end
  end

  // stage 2: divide by 2D and 20D
  logic [K_PW-1:0]  kp;
  logic [B_PW-1:0]  bp;
  logic [QK_W-1:0]  s2_qk_r;
  logic [QB_W-1:0]  s2_qb_r;
  logic [K_W-1:0]   s2_klo_r;
  logic [BZ_W-1:0]  s2_blo_r;
  logic             s2_bad_r;
  logic [LUM_W-1:0] s2_lum_r;

  assign kp = K_PW'(s1_mk_r) * K_PW'(s1_two_r ? RK_TWO : RK_ONE);
  assign bp = B_PW'(s1_mb_r) * B_PW'(s1_two_r ? RB_TWO : RB_ONE);

  always_ff @(posedge clk) begin
    if (ctrl.adv[2]) begin
      s2_qk_r  <= kp[SK +: QK_W];
      s2_qb_r  <= bp[SB +: QB_W];
      s2_klo_r <= s1_klo_r;
      s2_blo_r <= s1_blo_r;
      s2_bad_r <= s1_bad_r;
      s2_lum_r <= s1_lum_r;
    end
  end

  // stage 3: factor and base level; unset speed forces zeros
  logic [K_W-1:0]   s3_k_r;
  logic [BZ_W-1:0]  s3_base_r;
  logic             s3_bad_r;
  logic [LUM_W-1:0] s3_lum_r;

  always_ff @(posedge clk) begin
    if (ctrl.adv[3]) begin
      s3_k_r    <= s2_bad_r ? '0 : s2_klo_r + K_W'(s2_qk_r);
      s3_base_r <= s2_bad_r ? '0 : s2_blo_r + BZ_W'(s2_qb_r);
      s3_bad_r  <= s2_bad_r;
      s3_lum_r  <= s2_lum_r;
    end
  end

  // stage 4: factor times luminance, base ratios
  logic [B5_PW-1:0]  b5p;
  logic [PROD_W-1:0] s4_prod_r;
  logic [K_W-1:0]    s4_k_r;
  logic [BZ_W-1:0]   s4_base_r;
  logic [BZ_W-1:0]   s4_bz2_r;
  logic [XZ1_W-1:0]  s4_xz1_r;
  logic [XZ2_W-1:0]  s4_xz2_r;
  logic              s4_bad_r;

  assign b5p = B5_PW'(s3_base_r) * B5_PW'(R5_X4);

  always_ff @(posedge clk) begin
    if (ctrl.adv[4]) begin
      s4_prod_r <= PROD_W'(s3_k_r) * PROD_W'(s3_lum_r);
      s4_k_r    <= s3_k_r;
      s4_base_r <= s3_base_r;
      s4_bz2_r  <= b5p[S5 +: BZ_W];
      s4_xz1_r  <= XZ1_W'(s3_base_r) * XZ1_W'(3);
      s4_xz2_r  <= XZ2_W'(s3_base_r) * XZ2_W'(5);
      s4_bad_r  <= s3_bad_r;
    end
  end

  // stage 5: divide by 1000
  logic [E_PW-1:0]  ep;
  logic [EZ1_W-1:0] s5_ent_r;
  logic [K_W-1:0]   s5_k_r;
  logic [BZ_W-1:0]  s5_base_r;
  logic [BZ_W-1:0]  s5_bz2_r;
  logic [XZ1_W-1:0] s5_xz1_r;
  logic [XZ2_W-1:0] s5_xz2_r;
  logic             s5_bad_r;

  assign ep = E_PW'(s4_prod_r) * E_PW'(RE);

  always_ff @(posedge clk) begin
    if (ctrl.adv[5]) begin
      s5_ent_r  <= ep[SE +: EZ1_W];
      s5_k_r    <= s4_k_r;
      s5_base_r <= s4_base_r;
      s5_bz2_r  <= s4_bz2_r;
      s5_xz1_r  <= s4_xz1_r;
      s5_xz2_r  <= s4_xz2_r;
      s5_bad_r  <= s4_bad_r;
    end
  end

  // stage 6: transition ratios, result register
  logic [T_PW-1:0] t15p;
  logic [T_PW-1:0] t5p;
  logic [T_PW-1:0] t2p;
  result_t         res_r;

  assign t15p = T_PW'(s5_ent_r) * T_PW'(R100_X15);
  assign t5p  = T_PW'(s5_ent_r) * T_PW'(R100_X5);
  assign t2p  = T_PW'(s5_ent_r) * T_PW'(R100_X2);

  always_ff @(posedge clk) begin
    if (ctrl.adv[6]) begin
      res_r.status           <= s5_bad_r;
      res_r.reduction_factor <= s5_k_r;
      res_r.entrance_zone1   <= s5_ent_r;
      res_r.entrance_zone2   <= EZ2_W'(s5_ent_r >> 1);
      res_r.transition_zone1 <= t15p[S100 +: TZ1_W];
      res_r.transition_zone2 <= t5p[S100 +: TZ2_W];
      res_r.transition_zone3 <= t2p[S100 +: TZ3_W];
      res_r.base_zone1       <= s5_base_r;
      res_r.base_zone2       <= s5_bz2_r;
      res_r.exit_zone1       <= s5_xz1_r;
      res_r.exit_zone2       <= s5_xz2_r;
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/core/tunnel_zone_luminance_calc_top.sv =====
// Top level of the tunnel zone luminance calculator: config, pipeline control, channels.
//
// in_chan carries one request: traffic flow and exterior luminance. out_chan carries
// one result per request: status, entrance reduction factor and the entrance,
// transition, base and exit zone levels. Both use valid/ready; a transfer happens on
// a rising edge with both high.
// cfg_we/cfg_index/cfg_wdata write design_speed (index 0) and two_way_traffic
// (index 1); write only while no request is in flight.
// Seven register stages, each with its own valid bit. An accepted request enters
// stage 0 and moves through stages 1 to 6 in order to out_chan. While out_chan.ready
// is high, one request per cycle is taken; no stage has more than one multiply in depth.
// When out_chan.ready is low the result holds and bubbles upstream still close
// up, so up to seven requests are held before in_chan.ready drops; nothing is
// dropped or repeated. Reset clears every valid bit and both config registers
// (speed unset: results report status 1 with zero levels).
// Only the low LUMINANCE_BITS bits of exterior luminance are used.
module tunnel_zone_luminance_calc_top
  import tzlc_pkg::*;
#(
  parameter int LUMINANCE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tzlc_in_if.sink               in_chan,
  tzlc_out_if.source            out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LUM_W = (LUMINANCE_BITS < LUM_IN_W) ? LUMINANCE_BITS : LUM_IN_W;

  logic [SPEED_W-1:0] speed_r;
  logic               two_way_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= '0;
      two_way_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DESIGN_SPEED: speed_r   <= cfg_wdata[SPEED_W-1:0];
        CFG_TWO_WAY:      two_way_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // valid bit per stage; a stage loads when empty or when the next one moves
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;
  pipe_ctrl_t      ctrl;
  cfg_t            cfg;
  result_t         res;

  always_comb begin
    rdy[NSTG] = out_chan.ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    ctrl.adv[0] = in_chan.valid && rdy[0];
    v_nxt[0]    = rdy[0] ? in_chan.valid : v_r[0];
    for (int i = 1; i < NSTG; i++) begin
      ctrl.adv[i] = v_r[i-1] && rdy[i];
      v_nxt[i]    = rdy[i] ? v_r[i-1] : v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign cfg.design_speed = speed_r;
  assign cfg.two_way      = two_way_r;

  tzlc_datapath #(
    .LUM_W (LUM_W)
  ) u_datapath (
    .clk     (clk),
    .ctrl    (ctrl),
    .cfg     (cfg),
    .flow_in (in_chan.traffic_flow),
    .lum_in  (in_chan.exterior_luminance),
    .res     (res)
  );

  assign in_chan.ready             = rdy[0];
  assign out_chan.valid            = v_r[NSTG-1];
  assign out_chan.status           = res.status;
  assign out_chan.reduction_factor = res.reduction_factor;
  assign out_chan.entrance_zone1   = res.entrance_zone1;
  assign out_chan.entrance_zone2   = res.entrance_zone2;
  assign out_chan.transition_zone1 = res.transition_zone1;
  assign out_chan.transition_zone2 = res.transition_zone2;
  assign out_chan.transition_zone3 = res.transition_zone3;
  assign out_chan.base_zone1       = res.base_zone1;
  assign out_chan.base_zone2       = res.base_zone2;
  assign out_chan.exit_zone1       = res.exit_zone1;
  assign out_chan.exit_zone2       = res.exit_zone2;

  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> v_r[0])
    else $error("accepted request not captured in first stage");

  a_unset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status |->
      out_chan.reduction_factor == '0 && out_chan.entrance_zone1 == '0 &&
      out_chan.base_zone1 == '0 && out_chan.exit_zone2 == '0)
    else $error("unset speed result carries nonzero levels");

  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.status |->
      out_chan.reduction_factor >= K_W'(1000) && out_chan.reduction_factor <= K_W'(7000) &&
      out_chan.base_zone1 <= BZ_W'(1000))
    else $error("reduction factor or base level outside its row bounds");

endmodule

// ===== tb/tunnel_zone_luminance_calc_top_tb.sv =====
// Self-checking testbench for the tunnel zone luminance calculator top level.
`timescale 1ns / 1ps

module tunnel_zone_luminance_calc_top_tb
  import tzlc_pkg::*;
();

  localparam int LUM_BITS    = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam int N_PHASES    = 12;
  localparam int PHASE_REQS  = 158;
  localparam int MAX_PRINTS  = 100;

  typedef struct packed {
    logic [FLOW_W-1:0]   flow;
    logic [LUM_IN_W-1:0] lum;
  } zone_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DESIGN_SPEED;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  tzlc_in_if  in_chan ();
  tzlc_out_if out_chan ();

  tunnel_zone_luminance_calc_top #(
    .LUMINANCE_BITS(LUM_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [SPEED_W-1:0] speed_cfg = SPEED_UNSET;
  logic               two_way_cfg = 1'b0;

  zone_req_t req_q[$];
  result_t   levels_due[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        cycles = 0;
  bit        no_gaps = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit take_gap();
    return !no_gaps && ($urandom_range(99) < 11);
  endfunction

  // clamped interpolation numerator, scaled by the flow span
  function automatic longint clamped_num(longint hi, longint lo, longint flow, longint d,
                                         longint h);
    longint n;
    n = hi * d + (hi - lo) * (flow - h);
    if (n > hi * d) n = hi * d;
    if (n < lo * d) n = lo * d;
    return n;
  endfunction

  function automatic result_t zone_levels(logic [FLOW_W-1:0] flow,
                                          logic [LUM_IN_W-1:0] lum);
    result_t r;
    longint  kmax, kmin, bmax, bmin, d, h, n, k, base, ent, lum_used;
    r = '0;
    if (speed_cfg == SPEED_UNSET) begin
      r.status = 1'b1;
      return r;
    end
    case (speed_cfg)
      SPEED_120: begin
        kmax = 7000; kmin = 5000; bmax = 10000; bmin = 4500;
      end
      SPEED_100: begin
        kmax = 4500; kmin = 3500; bmax = 6500; bmin = 3000;
      end
      SPEED_80: begin
        kmax = 3500; kmin = 2500; bmax = 3500; bmin = 1500;
      end
      SPEED_60: begin
        kmax = 2200; kmin = 1500; bmax = 2500; bmin = 1000;
      end
      default: begin
        kmax = 1200; kmin = 1000; bmax = 10000; bmin = 1000;
      end
    endcase
    d = two_way_cfg ? 470 : 850;
    h = two_way_cfg ? 650 : 1200;
    n = clamped_num(kmax, kmin, longint'(flow), d, h);
    k = (2 * n + d) / (2 * d);
    n = clamped_num(bmax, bmin, longint'(flow), d, h);
    base = (2 * n + 10 * d) / (20 * d);
    lum_used = longint'(lum) & ((64'sd1 <<< LUM_BITS) - 1);
    ent = k * lum_used / 1000;
    r.reduction_factor = K_W'(k);
    r.entrance_zone1   = EZ1_W'(ent);
    r.entrance_zone2   = EZ2_W'(ent / 2);
    r.transition_zone1 = TZ1_W'(ent * 15 / 100);
    r.transition_zone2 = TZ2_W'(ent * 5 / 100);
    r.transition_zone3 = TZ3_W'(ent * 2 / 100);
    r.base_zone1       = BZ_W'(base);
    r.base_zone2       = BZ_W'(base * 80 / 100);
    r.exit_zone1       = XZ1_W'(3 * base);
    r.exit_zone2       = XZ2_W'(5 * base);
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatches < MAX_PRINTS)
      $display("[%0t] result %0d %s: got %0d, expected %0d", $time, results_seen, what,
               got, want);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk) begin : drive_req
    zone_req_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        levels_due.push_back(zone_levels(in_chan.traffic_flow, in_chan.exterior_luminance));
      if (!in_chan.valid || in_chan.ready) begin
        if (req_q.size() != 0 && !take_gap()) begin
          nxt = req_q.pop_front();
          in_chan.valid              <= 1'b1;
          in_chan.traffic_flow       <= nxt.flow;
          in_chan.exterior_luminance <= nxt.lum;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_result
    result_t got, want;
    if (!rst_n) begin
      out_chan.ready <= 1'b1;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{status: out_chan.status, reduction_factor: out_chan.reduction_factor,
                entrance_zone1: out_chan.entrance_zone1,
                entrance_zone2: out_chan.entrance_zone2,
                transition_zone1: out_chan.transition_zone1,
                transition_zone2: out_chan.transition_zone2,
                transition_zone3: out_chan.transition_zone3,
                base_zone1: out_chan.base_zone1, base_zone2: out_chan.base_zone2,
                exit_zone1: out_chan.exit_zone1, exit_zone2: out_chan.exit_zone2};
        if (levels_due.size() == 0) begin
          report_mismatch("unexpected result, status", got.status, 0);
        end else begin
          want = levels_due.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.reduction_factor !== want.reduction_factor)
            report_mismatch("reduction_factor", got.reduction_factor, want.reduction_factor);
          if (got.entrance_zone1 !== want.entrance_zone1)
            report_mismatch("entrance_zone1", got.entrance_zone1, want.entrance_zone1);
          if (got.entrance_zone2 !== want.entrance_zone2)
            report_mismatch("entrance_zone2", got.entrance_zone2, want.entrance_zone2);
          if (got.transition_zone1 !== want.transition_zone1)
            report_mismatch("transition_zone1", got.transition_zone1, want.transition_zone1);
          if (got.transition_zone2 !== want.transition_zone2)
            report_mismatch("transition_zone2", got.transition_zone2, want.transition_zone2);
          if (got.transition_zone3 !== want.transition_zone3)
            report_mismatch("transition_zone3", got.transition_zone3, want.transition_zone3);
          if (got.base_zone1 !== want.base_zone1)
            report_mismatch("base_zone1", got.base_zone1, want.base_zone1);
          if (got.base_zone2 !== want.base_zone2)
            report_mismatch("base_zone2", got.base_zone2, want.base_zone2);
          if (got.exit_zone1 !== want.exit_zone1)
            report_mismatch("exit_zone1", got.exit_zone1, want.exit_zone1);
          if (got.exit_zone2 !== want.exit_zone2)
            report_mismatch("exit_zone2", got.exit_zone2, want.exit_zone2);
        end
        results_seen++;
      end
      out_chan.ready <= !take_gap();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tunnel_zone_luminance_calc_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_DESIGN_SPEED) speed_cfg = val;
    else two_way_cfg = val[0];
  endtask

  task automatic set_mode(logic [SPEED_W-1:0] speed, logic two_way);
    write_reg(CFG_DESIGN_SPEED, speed);
    write_reg(CFG_TWO_WAY, CFG_DATA_W'(two_way));
    @(negedge clk);
  endtask

  task automatic add_req(int flow, int lum);
    req_q.push_back('{flow: FLOW_W'(flow), lum: LUM_IN_W'(lum)});
  endtask

  // wait until every queued request has been taken and answered
  task automatic drain();
    do @(negedge clk);
    while (req_q.size() != 0 || in_chan.valid || levels_due.size() != 0);
  endtask

  initial begin
    int lo, hi, sel, flow, lum;
    logic [SPEED_W-1:0] speed;
    logic               two_way;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // speed left unset after reset
    add_req(0, 0);
    add_req(16'hFFFF, 16'hFFFF);
    add_req(775, 1234);
    drain();

    set_mode(SPEED_120, 1'b0);
    add_req(0, 16'hFFFF);
    add_req(349, 16'hFFFF);
    add_req(350, 1000);
    add_req(351, 1);
    add_req(775, 0);
    add_req(1199, 40000);
    add_req(1200, 16'hFFFF);
    add_req(1201, 16'hAAAA);
    add_req(16'hFFFF, 16'h5555);
    drain();

    // speed outside the table, two-way flow points
    set_mode(SPEED_W'(77), 1'b1);
    add_req(179, 16'hFFFF);
    add_req(180, 500);
    add_req(415, 999);
    add_req(650, 16'hFFFF);
    add_req(651, 3);
    drain();

    set_mode(SPEED_60, 1'b1);
    add_req(0, 16'hFFFF);
    add_req(16'hFFFF, 16'hFFFF);
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: speed = 8'd255;
        1: speed = 8'd1;
        2: speed = SPEED_UNSET;
        default: begin
          sel = $urandom_range(9);
          if (sel < 2) speed = SPEED_120;
          else if (sel < 4) speed = SPEED_100;
          else if (sel < 6) speed = SPEED_80;
          else if (sel < 8) speed = SPEED_60;
          else speed = SPEED_W'($urandom_range(255, 1));
        end
      endcase
      two_way = (p < 2) ? p[0] : 1'($urandom_range(1));
      set_mode(speed, two_way);
      no_gaps = (p == 6);
      lo = two_way ? 180 : 350;
      hi = two_way ? 650 : 1200;
      for (int i = 0; i < PHASE_REQS; i++) begin
        sel = $urandom_range(99);
        if (sel < 60) flow = $urandom_range(hi + 150, lo - 150);
        else if (sel < 80) flow = ($urandom_range(1) ? lo : hi) + int'($urandom_range(6)) - 3;
        else flow = $urandom_range(16'hFFFF);
        sel = $urandom_range(99);
        if (sel < 70) lum = $urandom_range(16'hFFFF);
        else if (sel < 85) lum = $urandom_range(200);
        else lum = 16'hFFFF - int'($urandom_range(200));
        add_req(flow, lum);
      end
      drain();
      no_gaps = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("tunnel_zone_luminance_calc_top verification clean");
    end else begin
      $display("tunnel_zone_luminance_calc_top verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/tzlc_pkg.sv
rtl/core/tzlc_if.sv
rtl/core/tzlc_datapath.sv
rtl/core/tunnel_zone_luminance_calc_top.sv
tb/tunnel_zone_luminance_calc_top_tb.sv
